// ----- src/ged_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ged_pkg
// Shared types, sizes and helpers of the grayscale erode / dilate window.
// ----------------------------------------------------------------------------
package ged_pkg;

  localparam int MAX_RADIUS   = 3;
  localparam int WIN          = 2 * MAX_RADIUS + 1;
  localparam int LINES        = 2 * MAX_RADIUS;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W        = 11;
  localparam int RAD_W        = 2;
  localparam int MASK_SIDE    = 7;
  localparam int MASK_CENTRE  = 3;
  localparam int MASK_W       = MASK_SIDE * MASK_SIDE;
  localparam int MASK_IDX_W   = $clog2(MASK_W);
  localparam int POS_W        = $clog2(MAX_WIDTH * HEIGHT_LIMIT) + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = MASK_W;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN-1:0][PIX_W-1:0] column_t;
  typedef logic [LINES-1:0][PIX_W-1:0] line_t;

  typedef struct packed {
    logic [WIN-1:0] use_en;
    logic [WIN-1:0] in_img;
  } cell_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE      = 3'd0,
    CFG_RADIUS       = 3'd1,
    CFG_SE_MASK      = 3'd2,
    CFG_BORDER_VALUE = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_idx_t;

  localparam pix_t ERODE_INIT  = 8'd255;
  localparam pix_t DILATE_INIT = 8'd0;

  function automatic pix_t pick(pix_t a, pix_t b, logic dilate);
    if (dilate) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- src/ged_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ged_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ged_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ged_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ged_cell
// One window column: shifts in from its neighbor and reduces its pixels.
// ----------------------------------------------------------------------------
module ged_cell (
  input  logic              clk,
  input  logic              shift,
  input  logic              adv,
  input  ged_pkg::column_t  col_in,
  output ged_pkg::column_t  col_out,
  input  ged_pkg::cell_sel_t sel,
  input  logic              op_mode,
  input  ged_pkg::pix_t     border_value,
  output ged_pkg::pix_t     red
);
  import ged_pkg::*;

  column_t col_q;
  pix_t    red_next;
  pix_t    elem;

  assign col_out = col_q;

  always_comb begin
    red_next = op_mode ? DILATE_INIT : ERODE_INIT;
    elem = '0;
    for (int j = 0; j < WIN; j++) begin
      if (!sel.use_en[j]) begin
        elem = op_mode ? DILATE_INIT : ERODE_INIT;
      end else if (sel.in_img[j]) begin
        elem = col_q[j];
      end else begin
        elem = border_value;
      end
      red_next = pick(red_next, elem, op_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
    if (adv) begin
      red <= red_next;
    end
  end

endmodule

// ----- src/grayscale_erode_dilate_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_erode_dilate_window
// Flat structuring element erosion / dilation over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock once the window
// is filled, while the output does not stall. Result for frame position
// (y, x) follows the request at linear position (y + r) * W + (x + r); the
// source appends r * W + r flush requests after a frame. Each request passes
// the line buffer read, the window column cells with their column reduction
// and the final reduction over the seven cells before the output register.
// The six line buffers share one 48-bit RAM, read and written once per pixel.
// ----------------------------------------------------------------------------
module grayscale_erode_dilate_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ged_pkg::PIX_W-1:0]       pixel_in,
  input  logic                            flush,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ged_pkg::PIX_W-1:0]       pixel_out,
  output logic                            frame_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ged_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ged_pkg::CFG_W-1:0]       cfg_data
);
  import ged_pkg::*;

  // configuration
  logic              op_mode;
  logic [RAD_W-1:0]  radius;
  logic [MASK_W-1:0] se_mask;
  pix_t              border_value;
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode      <= 1'b0;
      radius       <= RAD_W'(1);
      se_mask      <= '1;
      border_value <= '0;
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OP_MODE:      op_mode      <= cfg_data[0];
        CFG_RADIUS:       radius       <= cfg_data[RAD_W-1:0];
        CFG_SE_MASK:      se_mask      <= cfg_data[MASK_W-1:0];
        CFG_BORDER_VALUE: border_value <= cfg_data[PIX_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [DIM_W-1:0] w_c, h_c;
  logic [RAD_W-1:0] r_c;
  logic [POS_W-1:0] total, delay;

  always_comb begin
    if (frame_width == '0) begin
      w_c = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      w_c = DIM_W'(MAX_WIDTH);
    end else begin
      w_c = frame_width;
    end
    if (frame_height == '0) begin
      h_c = DIM_W'(1);
    end else if (frame_height > DIM_W'(HEIGHT_LIMIT)) begin
      h_c = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_c = frame_height;
    end
    r_c = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
    total = POS_W'(w_c) * POS_W'(h_c);
    delay = POS_W'(r_c) * POS_W'(w_c) + POS_W'(r_c);
  end

  // output buffer and skid stage
  logic adv;
  logic oreg_v, skid_v;
  pix_t oreg_pix, skid_pix;
  logic oreg_fend, skid_fend;

  assign adv      = !skid_v;
  assign in_stall = skid_v;

  // stage 0: stream position
  logic [POS_W-1:0] pos, q;
  logic [COL_W-1:0] col, ox;
  logic [ROW_W-1:0] oy;
  logic acc, in_frame, ign, past_delay, overrun, res_now, fend_now, enter;
  logic [DIM_W-1:0] col_inc, ox_inc;

  always_comb begin
    acc        = in_valid && !in_stall;
    in_frame   = pos < total;
    ign        = flush && in_frame;
    past_delay = pos >= delay;
    q          = pos - delay;
    overrun    = past_delay && (q >= total);
    res_now    = past_delay && !overrun;
    fend_now   = res_now && (q == total - POS_W'(1));
    enter      = acc && !ign && !overrun;
    col_inc    = DIM_W'(col) + DIM_W'(1);
    ox_inc     = DIM_W'(ox) + DIM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      col <= '0;
      ox  <= '0;
      oy  <= '0;
    end else if (acc && !ign) begin
      if (overrun || fend_now) begin
        pos <= '0;
        col <= '0;
        ox  <= '0;
        oy  <= '0;
      end else begin
        pos <= pos + POS_W'(1);
        col <= (col_inc >= w_c) ? '0 : col_inc[COL_W-1:0];
        if (res_now) begin
          if (ox_inc >= w_c) begin
            ox <= '0;
            oy <= oy + ROW_W'(1);
          end else begin
            ox <= ox_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  // stage 1: line buffer taps
  logic             s1_v, s1_res, s1_fend, byp;
  logic [ROW_W-1:0] s1_oy;
  logic [COL_W-1:0] s1_ox, s1_col;
  pix_t             s1_pix;
  line_t            byp_data, rdata, lines, wdata;
  column_t          taps;

  always_comb begin
    lines   = byp ? byp_data : rdata;
    taps[0] = s1_pix;
    for (int k = 0; k < LINES; k++) begin
      taps[k+1] = lines[k];
      wdata[k]  = taps[k];
    end
  end

  ged_ram #(
    .WIDTH(LINES * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (adv && s1_v),
    .waddr(s1_col),
    .wdata(wdata),
    .re   (enter),
    .raddr(col),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= enter;
    end
    if (enter) begin
      s1_res   <= res_now;
      s1_fend  <= fend_now;
      s1_oy    <= oy;
      s1_ox    <= ox;
      s1_col   <= col;
      s1_pix   <= pixel_in;
      byp      <= s1_v && (s1_col == col);
      byp_data <= wdata;
    end
  end

  // stage 2: window cells
  logic             s2_res, s2_fend;
  logic [ROW_W-1:0] s2_oy;
  logic [COL_W-1:0] s2_ox;
  column_t          cell_col [WIN];
  pix_t             cell_red [WIN];
  cell_sel_t        cell_sel [WIN];
  logic [WIN-1:0]   row_ok, col_ok;

  always_comb begin
    int ry, cx, b;
    ry = 0;
    cx = 0;
    b  = 0;
    for (int j = 0; j < WIN; j++) begin
      ry = int'(s2_oy) + int'(r_c) - j;
      cx = int'(s2_ox) + int'(r_c) - j;
      row_ok[j] = (ry >= 0) && (ry < int'(h_c));
      col_ok[j] = (cx >= 0) && (cx < int'(w_c));
    end
    for (int m = 0; m < WIN; m++) begin
      for (int j = 0; j < WIN; j++) begin
        b = (int'(r_c) - j + MASK_CENTRE) * MASK_SIDE + (int'(r_c) - m + MASK_CENTRE);
        cell_sel[m].in_img[j] = row_ok[j] && col_ok[m];
        cell_sel[m].use_en[j] = (j <= 2 * int'(r_c)) && (m <= 2 * int'(r_c)) &&
                                se_mask[MASK_IDX_W'(b)];
      end
    end
  end

  for (genvar m = 0; m < WIN; m++) begin : g_cell
    ged_cell u_cell (
      .clk         (clk),
      .shift       (adv && s1_v),
      .adv         (adv),
      .col_in      ((m == 0) ? taps : cell_col[(m == 0) ? 0 : m - 1]),
      .col_out     (cell_col[m]),
      .sel         (cell_sel[m]),
      .op_mode     (op_mode),
      .border_value(border_value),
      .red         (cell_red[m])
    );
  end

  // stage 3: reduction across cells
  logic s3_res, s3_fend, push, pop;
  pix_t result;

  always_comb begin
    result = op_mode ? DILATE_INIT : ERODE_INIT;
    for (int m = 0; m < WIN; m++) begin
      result = pick(result, cell_red[m], op_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res <= 1'b0;
      s3_res <= 1'b0;
    end else if (adv) begin
      s2_res <= s1_v && s1_res;
      s3_res <= s2_res;
    end
    if (adv) begin
      s2_fend <= s1_fend;
      s2_oy   <= s1_oy;
      s2_ox   <= s1_ox;
      s3_fend <= s2_fend;
    end
  end

  // output
  assign push      = adv && s3_res;
  assign pop       = oreg_v && !out_stall;
  assign out_valid = oreg_v;
  assign pixel_out = oreg_pix;
  assign frame_end = oreg_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      oreg_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (push) begin
        if (!oreg_v || pop) begin
          oreg_v <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (pop) begin
        oreg_v <= skid_v;
        skid_v <= 1'b0;
      end
    end
    if (push && (!oreg_v || pop)) begin
      oreg_pix  <= result;
      oreg_fend <= s3_fend;
    end else if (push) begin
      skid_pix  <= result;
      skid_fend <= s3_fend;
    end else if (pop && skid_v) begin
      oreg_pix  <= skid_pix;
      oreg_fend <= skid_fend;
    end
  end

  a_skid_behind_oreg: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> oreg_v)
    else $error("skid holds a request while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && out_stall))
    else $error("skid filled without output stall");

  a_frame_end_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && !ign && fend_now) |=> (pos == '0 && ox == '0 && oy == '0))
    else $error("position counters not restarted after frame end");

endmodule
